// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the frame receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ----- hw/rtl/smfr_pkg.sv -----
// Types and constants shared by the frame receiver modules.
`timescale 1ns / 1ps
package smfr_pkg;

  localparam int unsigned WI_W        = 6;
  localparam int unsigned CMDQ_DEPTH  = 4;
  localparam int unsigned CQ_PW       = $clog2(CMDQ_DEPTH);

  localparam logic       OP_BYTE = 1'b0;
  localparam logic       OP_TICK = 1'b1;

  localparam logic [7:0] HDR_BYTE        = 8'h48;
  localparam logic [7:0] OVERHEAD        = 8'h05;
  localparam logic [7:0] STATE_FRAME_LEN = 8'h0B;
  localparam logic [7:0] ERR_FRAME_LEN   = 8'h07;
  localparam logic [7:0] TYPE_UPLOAD     = 8'h01;
  localparam logic [7:0] TYPE_DOWNLOAD   = 8'h02;
  localparam logic [7:0] TYPE_MODULE     = 8'hFE;
  localparam logic [7:0] TYPE_ERROR      = 8'hFF;
  localparam logic [7:0] ERR_SUM         = 8'h02;
  localparam logic [7:0] ERR_NOCMD       = 8'hFF;
  localparam logic [7:0] TIMEOUT_RESET   = 8'd100;
  localparam logic [7:0] ERR_SUM_BASE    = 8'(HDR_BYTE + ERR_FRAME_LEN + TYPE_ERROR);

  localparam logic [1:0] K_TX     = 2'd0;
  localparam logic [1:0] K_DATA   = 2'd1;
  localparam logic [1:0] K_MODULE = 2'd2;
  localparam logic [1:0] K_STATUS = 2'd3;

  localparam logic [2:0] FS_UPLOAD_ACK   = 3'd0;
  localparam logic [2:0] FS_DATA_UPDATE  = 3'd1;
  localparam logic [2:0] FS_CONTROL_ACK  = 3'd2;
  localparam logic [2:0] FS_MODULE_STATE = 3'd3;
  localparam logic [2:0] FS_PEER_ERR     = 3'd4;
  localparam logic [2:0] FS_SUM_ERR      = 3'd5;
  localparam logic [2:0] FS_UNKNOWN      = 3'd6;

  typedef struct packed {
    logic [WI_W-1:0] addr;
    logic [7:0]      data;
    logic            handle;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } back_stat_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [2:0] status;
    logic       last;
  } result_t;

  typedef enum logic [3:0] {
    BS_IDLE,
    BS_LEN_A,
    BS_LEN_B,
    BS_TYPE_A,
    BS_TYPE_B,
    BS_SUM_A,
    BS_SUM_B,
    BS_CHK_A,
    BS_CHK_B,
    BS_ECHO_A,
    BS_ECHO_B,
    BS_PAY_A,
    BS_PAY_B,
    BS_ERR,
    BS_STATUS
  } back_state_e;

endpackage

// ----- hw/rtl/smfr_front.sv -----
// Front end: takes requests, tracks frame position, length and silence timer.
`timescale 1ns / 1ps
module smfr_front import smfr_pkg::*; #(
  parameter int unsigned FRAME_MAX = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       push_i,
  input  logic       opcode_i,
  input  logic [7:0] rx_byte_i,
  output logic       full_o,
  input  q_stat_t    q_stat_i,
  output logic       cmd_push_o,
  output cmd_t       cmd_o
);

  localparam logic [7:0]      FM8 = 8'(FRAME_MAX);
  localparam logic [WI_W-1:0] FMW = WI_W'(FRAME_MAX);

  logic [WI_W-1:0] wi_q, wi_d, wi_a, wi_b;
  logic [7:0]      el_q, el_d, el_a;
  logic [7:0]      timer_q, timer_d, timer_dec;
  logic [7:0]      len_q, len_d;
  logic [7:0]      timeout_q;
  logic            accept, handle;

  assign full_o = q_stat_i.full;
  assign accept = push_i && !q_stat_i.full;

  always_comb begin
    wi_d       = wi_q;
    el_d       = el_q;
    timer_d    = timer_q;
    len_d      = len_q;
    cmd_push_o = 1'b0;
    handle     = 1'b0;
    wi_a       = wi_q;
    wi_b       = wi_q;
    el_a       = el_q;
    timer_dec  = 8'(timer_q - 8'd1);
    if (accept && opcode_i == OP_BYTE) begin
      cmd_push_o = 1'b1;
      if (wi_q == WI_W'(1)) begin
        len_d = rx_byte_i;
      end
      // once past the header slot, entry 0 holds the header
      if (wi_q != '0 || rx_byte_i == HDR_BYTE) begin
        wi_a = WI_W'(wi_q + WI_W'(1));
      end
      wi_b = wi_a;
      if (wi_a == WI_W'(4)) begin
        el_a = len_q;
        if (len_q > FM8) begin
          wi_b = '0;
        end
      end
      timer_d = timeout_q;
      el_d    = el_a;
      handle  = ({2'b00, wi_b} == el_a) && (wi_b != '0);
      if (handle) begin
        wi_b    = '0;
        timer_d = '0;
        el_d    = '0;
      end
      wi_d = (wi_b >= FMW) ? '0 : wi_b;
    end else if (accept && opcode_i == OP_TICK && timer_q != '0) begin
      timer_d = timer_dec;
      if (timer_dec == '0) begin
        wi_d = '0;
        el_d = '0;
      end
    end
  end

  always_comb begin
    cmd_o.addr   = wi_q;
    cmd_o.data   = rx_byte_i;
    cmd_o.handle = handle;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q      <= '0;
      el_q      <= '0;
      timer_q   <= '0;
      timeout_q <= TIMEOUT_RESET;
    end else begin
      wi_q    <= wi_d;
      el_q    <= el_d;
      timer_q <= timer_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
  end

endmodule

// ----- hw/rtl/smfr_cmdq.sv -----
// Command queue between the front end and the frame handler.
`timescale 1ns / 1ps
module smfr_cmdq import smfr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cmd_t    cmd_i,
  input  logic    pop_i,
  output cmd_t    cmd_o,
  output q_stat_t stat_o
);

  cmd_t             ent_q [CMDQ_DEPTH];
  logic [CQ_PW-1:0] wptr_q, rptr_q;
  logic [CQ_PW:0]   count_q;
  logic             do_push, do_pop;

  assign stat_o.full  = (count_q == (CQ_PW+1)'(CMDQ_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign cmd_o        = ent_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= CQ_PW'(wptr_q + CQ_PW'(1));
      end
      if (do_pop) begin
        rptr_q <= CQ_PW'(rptr_q + CQ_PW'(1));
      end
      if (do_push && !do_pop) begin
        count_q <= (CQ_PW+1)'(count_q + (CQ_PW+1)'(1));
      end else if (do_pop && !do_push) begin
        count_q <= (CQ_PW+1)'(count_q - (CQ_PW+1)'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wptr_q] <= cmd_i;
    end
  end

endmodule

// ----- hw/rtl/smfr_back.sv -----
// Frame handler: frame store, sum check, reply sequencer and result buffer.
`timescale 1ns / 1ps
module smfr_back import smfr_pkg::*; #(
  parameter int unsigned FRAME_MAX = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  q_stat_t    q_stat_i,
  output back_stat_t stat_o,
  input  logic       pop_i,
  output logic       empty_o,
  output result_t    result_o
);

  localparam int unsigned AW  = $clog2(FRAME_MAX);
  localparam logic [7:0]  FM8 = 8'(FRAME_MAX);

  function automatic logic [7:0] err_byte(logic [2:0] cnt, logic [7:0] rc, logic [7:0] code);
    logic [7:0] b;
    case (cnt)
      3'd0:    b = HDR_BYTE;
      3'd1:    b = ERR_FRAME_LEN;
      3'd2:    b = TYPE_ERROR;
      3'd3:    b = rc;
      3'd4:    b = code;
      3'd5:    b = 8'h00;
      default: b = 8'(ERR_SUM_BASE + rc + code);
    endcase
    return b;
  endfunction

  back_state_e state_q, state_d;

  logic [7:0] store_q [FRAME_MAX];
  logic [7:0] rdata_q;
  logic [7:0] idx_q, idx_d, acc_q, acc_d, len_q, len_d, type_q, type_d;
  logic [7:0] code_q, code_d, rc_q, rc_d;
  logic [2:0] status_q, status_d, cnt_q, cnt_d;
  logic [1:0] kind_q, kind_d;
  logic       mem_we, emit, room;
  result_t    emit_res;

  logic [7:0] n_idx, eff, pay, bound, idx_inc;
  logic       sum_done, echo_done, pay_done, sum_bad;

  // result buffer
  result_t    res_q [2];
  logic       owp_q, orp_q;
  logic [1:0] ocnt_q;
  logic       opush, opop;

  assign n_idx     = 8'(len_q - 8'd1);
  assign eff       = (len_q < FM8) ? len_q : FM8;
  assign pay       = (eff > OVERHEAD) ? 8'(eff - OVERHEAD) : 8'd0;
  assign bound     = (n_idx < FM8) ? n_idx : FM8;
  assign idx_inc   = 8'(idx_q + 8'd1);
  assign sum_done  = (idx_inc == bound);
  assign echo_done = (idx_inc == eff);
  assign pay_done  = (idx_inc == 8'(8'd4 + pay));
  assign sum_bad   = (acc_q != rdata_q);

  assign room        = (ocnt_q != 2'd2);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BS_IDLE: begin
        if (!q_stat_i.empty && cmd_i.handle) state_d = BS_LEN_A;
      end
      BS_LEN_A:  state_d = BS_LEN_B;
      BS_LEN_B:  state_d = BS_TYPE_A;
      BS_TYPE_A: state_d = BS_TYPE_B;
      BS_TYPE_B: state_d = (bound == '0) ? BS_CHK_A : BS_SUM_A;
      BS_SUM_A:  state_d = BS_SUM_B;
      BS_SUM_B:  state_d = sum_done ? BS_CHK_A : BS_SUM_A;
      BS_CHK_A:  state_d = BS_CHK_B;
      BS_CHK_B: begin
        if (sum_bad) begin
          state_d = BS_ERR;
        end else begin
          unique case (type_q) inside
            TYPE_UPLOAD, TYPE_ERROR: state_d = BS_STATUS;
            TYPE_DOWNLOAD: state_d = (eff == '0) ? BS_STATUS : BS_ECHO_A;
            TYPE_MODULE: state_d = (len_q == STATE_FRAME_LEN) ? BS_PAY_A : BS_STATUS;
            default: state_d = BS_ERR;
          endcase
        end
      end
      BS_ECHO_A: state_d = BS_ECHO_B;
      BS_ECHO_B: begin
        if (room) begin
          if (!echo_done) state_d = BS_ECHO_A;
          else            state_d = (pay == '0) ? BS_STATUS : BS_PAY_A;
        end
      end
      BS_PAY_A: state_d = BS_PAY_B;
      BS_PAY_B: begin
        if (room) state_d = pay_done ? BS_STATUS : BS_PAY_A;
      end
      BS_ERR: begin
        if (room && cnt_q == 3'd6) state_d = BS_STATUS;
      end
      BS_STATUS: begin
        if (room) state_d = BS_IDLE;
      end
      default: state_d = BS_IDLE;
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    acc_d       = acc_q;
    len_d       = len_q;
    type_d      = type_q;
    status_d    = status_q;
    code_d      = code_q;
    kind_d      = kind_q;
    cnt_d       = cnt_q;
    rc_d        = rc_q;
    mem_we      = 1'b0;
    stat_o.pop  = 1'b0;
    stat_o.busy = (state_q != BS_IDLE);
    emit        = 1'b0;
    emit_res    = '0;
    unique case (state_q)
      BS_IDLE: begin
        if (!q_stat_i.empty) begin
          stat_o.pop = 1'b1;
          mem_we     = 1'b1;
          if (cmd_i.handle) idx_d = 8'd1;
        end
      end
      BS_LEN_B: begin
        len_d = rdata_q;
        idx_d = 8'd2;
      end
      BS_TYPE_B: begin
        type_d = rdata_q;
        acc_d  = '0;
        idx_d  = (bound == '0) ? n_idx : 8'd0;
      end
      BS_SUM_B: begin
        acc_d = 8'(acc_q + rdata_q);
        idx_d = sum_done ? n_idx : idx_inc;
      end
      BS_CHK_B: begin
        if (sum_bad) begin
          code_d   = ERR_SUM;
          status_d = FS_SUM_ERR;
          cnt_d    = '0;
        end else begin
          unique case (type_q) inside
            TYPE_UPLOAD: status_d = FS_UPLOAD_ACK;
            TYPE_ERROR:  status_d = FS_PEER_ERR;
            TYPE_DOWNLOAD: begin
              status_d = FS_DATA_UPDATE;
              kind_d   = K_DATA;
              idx_d    = 8'd0;
            end
            TYPE_MODULE: begin
              if (len_q == STATE_FRAME_LEN) begin
                status_d = FS_MODULE_STATE;
                kind_d   = K_MODULE;
                idx_d    = 8'd4;
              end else begin
                status_d = FS_CONTROL_ACK;
              end
            end
            default: begin
              code_d   = ERR_NOCMD;
              status_d = FS_UNKNOWN;
              cnt_d    = '0;
            end
          endcase
        end
      end
      BS_ECHO_B: begin
        emit          = 1'b1;
        emit_res.kind = K_TX;
        emit_res.data = rdata_q;
        if (room) idx_d = echo_done ? 8'd4 : idx_inc;
      end
      BS_PAY_B: begin
        emit          = 1'b1;
        emit_res.kind = kind_q;
        emit_res.data = rdata_q;
        if (room) idx_d = idx_inc;
      end
      BS_ERR: begin
        emit          = 1'b1;
        emit_res.kind = K_TX;
        emit_res.data = err_byte(cnt_q, rc_q, code_q);
        if (room) begin
          if (cnt_q == 3'd6) rc_d = 8'(rc_q + 8'd1);
          else               cnt_d = 3'(cnt_q + 3'd1);
        end
      end
      BS_STATUS: begin
        emit            = 1'b1;
        emit_res.kind   = K_STATUS;
        emit_res.status = status_q;
        emit_res.last   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[cmd_i.addr[AW-1:0]] <= cmd_i.data;
    end
    // entries past the store read as zero
    rdata_q  <= (idx_q < FM8) ? store_q[idx_q[AW-1:0]] : 8'd0;
    idx_q    <= idx_d;
    acc_q    <= acc_d;
    len_q    <= len_d;
    type_q   <= type_d;
    status_q <= status_d;
    code_q   <= code_d;
    kind_q   <= kind_d;
    cnt_q    <= cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
      rc_q    <= '0;
    end else begin
      state_q <= state_d;
      rc_q    <= rc_d;
    end
  end

  assign opush    = emit && room;
  assign empty_o  = (ocnt_q == 2'd0);
  assign opop     = pop_i && !empty_o;
  assign result_o = res_q[orp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q  <= 1'b0;
      orp_q  <= 1'b0;
      ocnt_q <= '0;
    end else begin
      if (opush) owp_q <= !owp_q;
      if (opop)  orp_q <= !orp_q;
      if (opush && !opop) begin
        ocnt_q <= 2'(ocnt_q + 2'd1);
      end else if (opop && !opush) begin
        ocnt_q <= 2'(ocnt_q - 2'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (opush) begin
      res_q[owp_q] <= emit_res;
    end
  end

endmodule

// ----- hw/rtl/serial_module_frame_receiver_top.sv -----
// Bytes and ticks update front-end registers; stored bytes pass a 4-deep queue. A closing
// byte starts the handler: length, type, sum check, then echo, payload or error-reply bytes
// and the status, each held while the result buffer is full; the frame store has one
// registered read port. Throughput: one request per cycle while the queue has room. Up to
// 60 results/frame. Reset: control state, queue pointers and counts, reply counter and timer
// clear at once, timeout loads 100; frame store is not cleared and takes no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module serial_module_frame_receiver_top import smfr_pkg::*; #(
  parameter int unsigned FRAME_MAX = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       push,
  output logic       full,
  input  logic       opcode_i,
  input  logic [7:0] rx_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic [2:0] frame_status_o,
  output logic       last_o
);

  q_stat_t    q_stat;
  back_stat_t back_stat;
  cmd_t       cmd_in, cmd_head;
  logic       cmd_push;
  result_t    result;

  smfr_front #(.FRAME_MAX(FRAME_MAX)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .opcode_i    (opcode_i),
    .rx_byte_i   (rx_byte_i),
    .full_o      (full),
    .q_stat_i    (q_stat),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  smfr_cmdq u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .cmd_i  (cmd_in),
    .pop_i  (back_stat.pop),
    .cmd_o  (cmd_head),
    .stat_o (q_stat)
  );

  smfr_back #(.FRAME_MAX(FRAME_MAX)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_head),
    .q_stat_i (q_stat),
    .stat_o   (back_stat),
    .pop_i    (pop),
    .empty_o  (empty),
    .result_o (result)
  );

  assign out_kind_o     = result.kind;
  assign out_byte_o     = result.data;
  assign frame_status_o = result.status;
  assign last_o         = result.last;

  `ASSERT_NEVER(a_push_when_full, clk_i, rst_ni, cmd_push && q_stat.full)
  `ASSERT_AT(a_handle_starts, clk_i, rst_ni, (back_stat.pop && cmd_head.handle) |=> back_stat.busy)
  `ASSERT_NEVER(a_pop_while_busy, clk_i, rst_ni, back_stat.busy && back_stat.pop)
  `ASSERT_AT(a_last_is_status, clk_i, rst_ni, (!empty && last_o) |-> (out_kind_o == K_STATUS))

endmodule

// ----- tb/sv/tb_serial_module_frame_receiver_top.sv -----
// Testbench for the serial frame receiver: drives bytes and ticks, checks replies in a scoreboard.
`timescale 1ns / 1ps
module tb_serial_module_frame_receiver_top import smfr_pkg::*;;

  localparam int FRAME_LEN = 32;
  localparam int LIMIT = 1_000_000;
  localparam int SETTLE = 400;
  localparam logic [2:0] NO_STATUS = 3'd0;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;
  logic       push;
  logic       full;
  logic       opcode_i;
  logic [7:0] rx_byte_i;
  logic       empty;
  logic       pop;
  logic [1:0] out_kind_o;
  logic [7:0] out_byte_o;
  logic [2:0] frame_status_o;
  logic       last_o;

  class frame_reply_board;
    logic [7:0]  store [FRAME_LEN];
    logic [5:0]  wr_idx;
    logic [7:0]  exp_len;
    logic [7:0]  quiet;
    logic [7:0]  reply_cnt;
    logic [7:0]  timeout_ld;
    result_t     replies_due [$];
    int unsigned mismatches;

    function new();
      foreach (store[i]) store[i] = 8'h00;
      wr_idx = '0;
      exp_len = 8'h00;
      quiet = 8'h00;
      reply_cnt = 8'h00;
      timeout_ld = TIMEOUT_RESET;
      mismatches = 0;
    endfunction

    function void emit(logic [1:0] k, logic [7:0] b, logic [2:0] st, logic l);
      result_t r;
      r.kind = k;
      r.data = b;
      r.status = st;
      r.last = l;
      replies_due.push_back(r);
    endfunction

    function logic [7:0] rd(int unsigned i);
      return (i < FRAME_LEN) ? store[i] : 8'h00;
    endfunction

    function void push_error_reply(logic [7:0] code);
      logic [7:0] f [7];
      logic [7:0] s;
      f[0] = HDR_BYTE;
      f[1] = ERR_FRAME_LEN;
      f[2] = TYPE_ERROR;
      f[3] = reply_cnt;
      f[4] = code;
      f[5] = 8'h00;
      reply_cnt = reply_cnt + 8'd1;
      s = 8'h00;
      for (int i = 0; i < 6; i++) s += f[i];
      f[6] = s;
      for (int i = 0; i < 7; i++) emit(K_TX, f[i], NO_STATUS, 1'b0);
    endfunction

    function void close_frame();
      int unsigned len, n, eff, pay;
      logic [7:0] s;
      len = rd(1);
      n = (len - 1) & 32'hFF;
      eff = (len < FRAME_LEN) ? len : FRAME_LEN;
      pay = (eff > OVERHEAD) ? eff - OVERHEAD : 0;
      s = 8'h00;
      for (int i = 0; i < n && i < FRAME_LEN; i++) s += store[i];
      if (s != rd(n)) begin
        push_error_reply(ERR_SUM);
        emit(K_STATUS, 8'h00, FS_SUM_ERR, 1'b1);
        return;
      end
      case (rd(2))
        TYPE_UPLOAD: emit(K_STATUS, 8'h00, FS_UPLOAD_ACK, 1'b1);
        TYPE_DOWNLOAD: begin
          for (int i = 0; i < eff; i++) emit(K_TX, store[i], NO_STATUS, 1'b0);
          for (int i = 0; i < pay; i++) emit(K_DATA, store[4 + i], NO_STATUS, 1'b0);
          emit(K_STATUS, 8'h00, FS_DATA_UPDATE, 1'b1);
        end
        TYPE_MODULE: begin
          if (len != STATE_FRAME_LEN) begin
            emit(K_STATUS, 8'h00, FS_CONTROL_ACK, 1'b1);
          end else begin
            for (int i = 0; i < pay; i++) emit(K_MODULE, store[4 + i], NO_STATUS, 1'b0);
            emit(K_STATUS, 8'h00, FS_MODULE_STATE, 1'b1);
          end
        end
        TYPE_ERROR: emit(K_STATUS, 8'h00, FS_PEER_ERR, 1'b1);
        default: begin
          push_error_reply(ERR_NOCMD);
          emit(K_STATUS, 8'h00, FS_UNKNOWN, 1'b1);
        end
      endcase
    endfunction

    function void note_request(logic op, logic [7:0] b);
      if (op == OP_BYTE) begin
        if (wr_idx < FRAME_LEN) store[wr_idx] = b;
        if (store[0] == HDR_BYTE) wr_idx = wr_idx + 6'd1;
        if (wr_idx == 6'd4) begin
          exp_len = store[1];
          if (exp_len > FRAME_LEN) wr_idx = '0;
        end
        quiet = timeout_ld;
        if (wr_idx == exp_len && wr_idx != 0) begin
          close_frame();
          wr_idx = '0;
          quiet = 8'h00;
          exp_len = 8'h00;
        end
        if (wr_idx >= FRAME_LEN) wr_idx = '0;
      end else if (quiet != 0) begin
        quiet = quiet - 8'd1;
        // silence ran out: drop the partial frame
        if (quiet == 0) begin
          if (wr_idx == exp_len && wr_idx != 0) close_frame();
          wr_idx = '0;
          exp_len = 8'h00;
        end
      end
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_reply(result_t got);
      result_t want;
      if (replies_due.size() == 0) begin
        report_mismatch($sformatf("unexpected reply kind %0d byte %02h status %0d last %0d",
                                  got.kind, got.data, got.status, got.last));
        return;
      end
      want = replies_due.pop_front();
      if (got.kind !== want.kind || got.data !== want.data ||
          got.status !== want.status || got.last !== want.last)
        report_mismatch($sformatf("reply kind %0d/%0d byte %02h/%02h status %0d/%0d last %0d/%0d",
                                  got.kind, want.kind, got.data, want.data,
                                  got.status, want.status, got.last, want.last));
    endtask
  endclass

  frame_reply_board sb;
  int               tx_idle_pct;
  int               rx_idle_pct;
  int               rx_hold_req;
  int               hold_left;
  int               quota_items;
  bit               counting;
  int unsigned      cycle_cnt;
  result_t          seen;

  serial_module_frame_receiver_top #(
    .FRAME_MAX(FRAME_LEN)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push          (push),
    .full          (full),
    .opcode_i      (opcode_i),
    .rx_byte_i     (rx_byte_i),
    .empty         (empty),
    .pop           (pop),
    .out_kind_o    (out_kind_o),
    .out_byte_o    (out_byte_o),
    .frame_status_o(frame_status_o),
    .last_o        (last_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: random pop, with a long hold-off on request
  initial begin
    pop = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (pop && empty === 1'b0) begin
        seen.kind = out_kind_o;
        seen.data = out_byte_o;
        seen.status = frame_status_o;
        seen.last = last_o;
        sb.check_reply(seen);
      end
      if (rx_hold_req != 0) begin
        hold_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_request(logic op, logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    opcode_i <= op;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (full !== 1'b0) @(posedge clk_i);
    sb.note_request(op, b);
    if (counting) quota_items++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (sb.replies_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_timeout(logic [7:0] v);
    wait_drained();
    // no reply is pending, but a closing byte may still be in the handler
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.timeout_ld = v;
  endtask

  // Bring the receiver back to an empty frame with no stale short length
  task automatic resync();
    counting = 0;
    while (sb.wr_idx != 0 || sb.exp_len inside {[1:3]}) begin
      if (sb.quiet != 0) send_request(OP_TICK, 8'($urandom));
      else send_request(OP_BYTE, (sb.wr_idx == 0) ? HDR_BYTE : 8'($urandom));
    end
    counting = 1;
  endtask

  task automatic send_frame(int len, logic [7:0] ftype, bit good, int cut, int tick_pct);
    logic [7:0] fb [FRAME_LEN];
    logic [7:0] s;
    resync();
    fb[0] = HDR_BYTE;
    fb[1] = 8'(len);
    fb[2] = ftype;
    for (int i = 3; i < FRAME_LEN; i++) fb[i] = 8'($urandom);
    s = 8'h00;
    for (int i = 0; i < len - 1; i++) s += fb[i];
    fb[len - 1] = good ? s : s ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(99) < tick_pct) send_request(OP_TICK, 8'($urandom));
      send_request(OP_BYTE, fb[i]);
    end
  endtask

  task automatic random_sequence();
    int r;
    int len;
    logic [7:0] ft;
    r = $urandom_range(99);
    len = ($urandom_range(99) < 85) ? $urandom_range(4, 12) : $urandom_range(13, FRAME_LEN);
    case ($urandom_range(4))
      0: ft = TYPE_UPLOAD;
      1: ft = TYPE_DOWNLOAD;
      2: begin
        ft = TYPE_MODULE;
        if ($urandom_range(1)) len = STATE_FRAME_LEN;
      end
      3: ft = TYPE_ERROR;
      default: ft = 8'($urandom);
    endcase
    if (r < 70) begin
      send_frame(len, ft, $urandom_range(99) < 85, len, 4);
    end else if (r < 80) begin
      // truncated frame, left to time out
      send_frame(len, ft, 1'b1, $urandom_range(1, len - 1), 4);
    end else if (r < 90) begin
      send_request(OP_BYTE, HDR_BYTE);
      send_request(OP_BYTE, 8'($urandom));
      repeat ($urandom_range(0, 6)) send_request(OP_BYTE, 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 5)) send_request(1'($urandom), 8'($urandom));
    end
  endtask

  task automatic run_phase(int quota);
    quota_items = 0;
    counting = 1;
    while (quota_items < quota) random_sequence();
  endtask

  initial begin
    push = 1'b0;
    opcode_i = OP_BYTE;
    rx_byte_i = 8'h00;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 8'h00;
    rst_ni = 1'b0;
    rx_hold_req = 0;
    counting = 1;
    tx_idle_pct = 34;
    rx_idle_pct = 77;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Bytes before any header are dropped; a tick with the timer at rest does nothing
    send_request(OP_TICK, 8'hFF);
    send_request(OP_BYTE, 8'h00);
    send_request(OP_BYTE, 8'hFF);
    // A full-length download writes every store entry first
    send_frame(FRAME_LEN, TYPE_DOWNLOAD, 1'b1, FRAME_LEN, 0);
    send_frame(STATE_FRAME_LEN, TYPE_MODULE, 1'b1, STATE_FRAME_LEN, 0);
    send_frame(4, TYPE_MODULE, 1'b1, 4, 0);
    send_frame(4, TYPE_ERROR, 1'b1, 4, 0);
    send_frame(4, 8'h00, 1'b1, 4, 0);
    send_frame(4, TYPE_UPLOAD, 1'b0, 4, 0);
    send_frame(6, TYPE_DOWNLOAD, 1'b1, 6, 0);
    // Oversize length refuses the frame
    send_request(OP_BYTE, HDR_BYTE);
    send_request(OP_BYTE, 8'(FRAME_LEN + 1));
    send_request(OP_BYTE, 8'($urandom));
    send_request(OP_BYTE, 8'($urandom));

    // Zero timeout: ticks have no effect; a short length goes stale over an index wrap
    write_timeout(8'd0);
    resync();
    send_request(OP_BYTE, HDR_BYTE);
    send_request(OP_BYTE, 8'h02);
    repeat (FRAME_LEN - 2) begin
      if ($urandom_range(9) == 0) send_request(OP_TICK, 8'($urandom));
      send_request(OP_BYTE, 8'($urandom));
    end
    // completes on the stale length with byte 1 = 0, summing the whole store
    send_request(OP_BYTE, HDR_BYTE);
    send_request(OP_BYTE, 8'h00);

    tx_idle_pct = 77;
    rx_idle_pct = 34;
    write_timeout(8'd1);
    run_phase(8);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_timeout(8'd255);
    // Hold off the result side so the block fills up and stalls its input
    rx_hold_req = 800;
    send_frame(10, TYPE_DOWNLOAD, 1'b1, 10, 0);
    send_frame(10, TYPE_DOWNLOAD, 1'b1, 10, 0);

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.replies_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
